// ===== hw/rtl/oal_pkg.sv =====
// Shared constants for the ordered array list: port field widths, command codes
// and the operation codes that the control logic broadcasts to the entry cells.
// No dependencies.
package oal_pkg;

  // Fixed widths of the position and word fields on the ports.
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_LOCATE = 2'd3;

  // Operations that every cell of the chain carries out.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_ROTATE = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_DELETE = 2'd3;

endpackage

// ===== hw/rtl/oal_cell.sv =====
// One entry cell of the ordered array list chain.
// Depends on oal_pkg for the cell operation codes.
module oal_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic [1:0]            mode,
  input  logic [CNT_W-1:0]      pos,
  input  logic [CNT_W-1:0]      len,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] word_lo,
  input  logic [DATA_WIDTH-1:0] word_hi,
  output logic [DATA_WIDTH-1:0] word
);

  // This cell's 0-based index, and its 1-based list position.
  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    case (mode)
      oal_pkg::CELL_HOLD: begin
        word_next = word;
      end
      oal_pkg::CELL_ROTATE: begin
        word_next = word_hi;
      end
      oal_pkg::CELL_INSERT: begin
        // The target cell loads the new word; cells above it, up to the cell just past
        // the old end of the list, take the word from the cell below.
        if (IDX1 == pos) begin
          word_next = new_word;
        end else if (IDX >= pos && IDX <= len) begin
          word_next = word_lo;
        end
      end
      oal_pkg::CELL_DELETE: begin
        // Everything from the removed position upwards moves down by one.
        if (IDX1 >= pos) begin
          word_next = word_hi;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== hw/rtl/ordered_array_list.sv =====
// Ordered array list: a chain of entry cells with a small sequencer in front.
// Depends on oal_pkg and oal_cell.
//
//   Channel | Signals                                    | Direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_ready, command, position,      | to block
//           | value                                      |
//   out     | out_valid, out_ready, ok, element,          | from block
//           | found_at, count                            |
//
// Insert, and any command that fails its position check, goes from acceptance
// straight to the completion state, which loads the output register. Get and
// locate pass through the scan state first, and delete through scan and shift:
// the whole chain rotates once past the head cell, which holds the only read
// port and comparator. A new word is accepted as soon as the previous result has
// moved to the output register, even while that result is stalled. Reset clears
// the length and the handshake state; the entries are not cleared.
module ordered_array_list #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [oal_pkg::POS_W-1:0]         position,
  input  logic signed [oal_pkg::WORD_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic signed [oal_pkg::WORD_W-1:0] element,
  output logic [oal_pkg::POS_W-1:0]         found_at,
  output logic [oal_pkg::POS_W-1:0]         count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PW    = oal_pkg::POS_W;
  localparam int WW    = oal_pkg::WORD_W;
  localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state;
  logic [CNT_W-1:0]      len;
  logic [IDX_W-1:0]      cnt;
  logic [1:0]            cmd_q;
  logic [CNT_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  res_ok;
  logic [DATA_WIDTH-1:0] res_elem;
  logic [CNT_W-1:0]      res_found;

  logic                  accept;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      len_c;
  logic                  ins_ok;
  logic                  rd_ok;
  logic [DATA_WIDTH-1:0] new_word;
  logic [1:0]            cell_mode;
  logic [CNT_W-1:0]      cell_pos;
  logic [DATA_WIDTH-1:0] words [DEPTH];
  logic [DATA_WIDTH-1:0] head;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pos_c    = CMP_W'(position);
  assign len_c    = CMP_W'(len);
  assign ins_ok   = (pos_c != '0) && (pos_c <= len_c + CMP_W'(1)) &&
                    (len != CNT_W'(DEPTH));
  assign rd_ok    = (pos_c != '0) && (pos_c <= len_c);
  assign new_word = DATA_WIDTH'($unsigned(value));
  assign head     = words[0];

  // An insert shifts the chain in the cycle it is accepted; a valid position
  // always fits the cell position width.
  always_comb begin
    cell_mode = oal_pkg::CELL_HOLD;
    cell_pos  = pos_q;
    case (state)
      ST_IDLE: begin
        if (accept && command == oal_pkg::CMD_INSERT && ins_ok) begin
          cell_mode = oal_pkg::CELL_INSERT;
          cell_pos  = CNT_W'(position);
        end
      end
      ST_SCAN: begin
        cell_mode = oal_pkg::CELL_ROTATE;
      end
      ST_SHIFT: begin
        cell_mode = oal_pkg::CELL_DELETE;
      end
      default: begin
        cell_mode = oal_pkg::CELL_HOLD;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .mode     (cell_mode),
      .pos      (cell_pos),
      .len      (len),
      .new_word (new_word),
      .word_lo  (words[(i + DEPTH - 1) % DEPTH]),
      .word_hi  (words[(i + 1) % DEPTH]),
      .word     (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The completion state reloads the output itself when it hands over.
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q     <= command;
            pos_q     <= CNT_W'(position);
            val_q     <= new_word;
            res_elem  <= '0;
            res_found <= '0;
            cnt       <= '0;
            if (command == oal_pkg::CMD_INSERT) begin
              res_ok <= ins_ok;
              if (ins_ok) begin
                len <= len + CNT_W'(1);
              end
              state <= ST_DONE;
            end else if (command == oal_pkg::CMD_LOCATE) begin
              res_ok <= 1'b1;
              state  <= ST_SCAN;
            end else begin
              res_ok <= rd_ok;
              state  <= rd_ok ? ST_SCAN : ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // At scan step k the head cell holds the entry at index k.
          cnt <= cnt + IDX_W'(1);
          if (cmd_q != oal_pkg::CMD_LOCATE && CNT_W'(cnt) + CNT_W'(1) == pos_q) begin
            res_elem <= head;
          end
          if (cmd_q == oal_pkg::CMD_LOCATE && res_found == '0 &&
              CNT_W'(cnt) < len && head == val_q) begin
            res_found <= CNT_W'(cnt) + CNT_W'(1);
          end
          if (cnt == IDX_W'(DEPTH - 1)) begin
            state <= (cmd_q == oal_pkg::CMD_DELETE) ? ST_SHIFT : ST_DONE;
          end
        end
        ST_SHIFT: begin
          len   <= len - CNT_W'(1);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            ok        <= res_ok;
            element   <= WW'($signed(res_elem));
            found_at  <= PW'(res_found);
            count     <= PW'(len);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CNT_W'(DEPTH))
    else $error("list length beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && command == oal_pkg::CMD_INSERT && ins_ok) |=>
      (len == $past(len) + CNT_W'(1)))
    else $error("successful insert did not grow the list");

  a_scan_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt != IDX_W'(DEPTH - 1)) |=>
      (state == ST_SCAN && cnt == $past(cnt) + IDX_W'(1)))
    else $error("rotation pass ended early or skipped a step");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result word loaded outside the completion state");

  a_fail_is_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (element == '0 && found_at == '0))
    else $error("failed command carries a non-zero result");

endmodule
